// ===== hw/rtl/bitmap_run_allocator_core_macros.svh =====
// assertion macros for the bitmap run allocator checker
// no dependencies
`ifndef BITMAP_RUN_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define BRA_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bra_pkg.sv =====
// shared types and constants for the bitmap run allocator
// no dependencies
package bra_pkg;

    localparam int UNITS_DEF     = 4096;
    localparam int WORD_BITS_DEF = 32;
    localparam int MAX_RUN_DEF   = 64;

    localparam int UNIT_W   = 13;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOC    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREED    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd3;

    typedef struct packed {
        logic clear;
        logic accept;
        logic div1;
        logic div2;
        logic read;
        logic load;
        logic scan;
        logic free_op;
        logic err;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic in_free;
        logic alloc_bad;
        logic free_bad;
        logic op_free;
        logic slot_free;
        logic have_clear;
        logic run_end;
    } dp_stat_t;

endpackage

// ===== hw/rtl/bra_ram.sv =====
// generic simple dual-port ram with registered read
// no dependencies
module bra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/bra_ctrl.sv =====
// sequencing state machine for the bitmap run allocator
// depends on bra_pkg
module bra_ctrl
    import bra_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd,
    output logic     req_ready
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_DIV1  = 9'b000000100,
        S_DIV2  = 9'b000001000,
        S_READ  = 9'b000010000,
        S_LOAD  = 9'b000100000,
        S_SCAN  = 9'b001000000,
        S_FREE  = 9'b010000000,
        S_ERR   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (stat.in_free)
                    begin
                        state_next = stat.free_bad ? S_ERR : S_DIV1;
                    end
                    else
                    begin
                        state_next = stat.alloc_bad ? S_ERR : S_READ;
                    end
                end
            end
            S_DIV1: state_next = S_DIV2;
            S_DIV2: state_next = S_READ;
            S_READ: state_next = S_LOAD;
            S_LOAD: state_next = stat.op_free ? S_FREE : S_SCAN;
            S_SCAN:
            begin
                if (!stat.have_clear)
                begin
                    state_next = S_READ;
                end
                else if (stat.slot_free && stat.run_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FREE, S_ERR:
            begin
                if (stat.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd.clear   = (state_reg == S_CLEAR);
        cmd.accept  = (state_reg == S_IDLE) && req_valid;
        cmd.div1    = (state_reg == S_DIV1);
        cmd.div2    = (state_reg == S_DIV2);
        cmd.read    = (state_reg == S_READ);
        cmd.load    = (state_reg == S_LOAD);
        cmd.scan    = (state_reg == S_SCAN);
        cmd.free_op = (state_reg == S_FREE);
        cmd.err     = (state_reg == S_ERR);
    end

    assign req_ready = (state_reg == S_IDLE);

endmodule

// ===== hw/rtl/bra_datapath.sv =====
// bitmap storage, free counter, unit search and response register
// depends on bra_pkg and bra_ram
module bra_datapath
    import bra_pkg::*;
#(
    parameter int UNITS     = UNITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int MAX_RUN   = MAX_RUN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_cmd_t            cmd,
    output dp_stat_t            stat,
    input  logic                func,
    input  logic [COUNT_W-1:0]  count,
    input  logic [UNIT_W-1:0]   unit_number,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [UNIT_W-1:0]   unit,
    output logic [STATUS_W-1:0] status,
    output logic                last,
    output logic [UNIT_W-1:0]   free_left
);

    localparam int MAP_WORDS = (UNITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int CW_RAW    = $clog2(UNITS + WORD_BITS + 1);
    localparam int CW        = (CW_RAW > UNIT_W) ? CW_RAW : UNIT_W;
    localparam int DIV_SHIFT = 16;
    localparam int DIV_RECIP = (1 << DIV_SHIFT) / WORD_BITS;
    localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
    localparam int PW        = UNIT_W + RECIP_W;
    localparam int DW        = UNIT_W + 7;

    logic                 func_reg, func_next;
    logic [UNIT_W-1:0]    unum_reg, unum_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [AW-1:0]        cur_reg, cur_next;
    logic [CW-1:0]        base_reg, base_next;
    logic [AW-1:0]        hint_reg, hint_next;
    logic [CW-1:0]        hint_base_reg, hint_base_next;
    logic [CW-1:0]        free_cnt_reg, free_cnt_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [BW-1:0]        bit_reg, bit_next;
    logic [UNIT_W-1:0]    q_reg, q_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [UNIT_W-1:0]    unit_reg, unit_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 last_reg, last_next;
    logic [UNIT_W-1:0]    free_left_reg, free_left_next;

    logic                 ram_we;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [UNIT_W-1:0]    idx;
    logic [PW-1:0]        prod;
    logic [DW-1:0]        qw;
    logic [DW-1:0]        r_raw;
    logic                 r_fix;
    logic [DW-1:0]        r_fin;
    logic [UNIT_W-1:0]    q_fin;
    logic [BW-1:0]        fz_pos;
    logic                 have_clear;
    logic [WORD_BITS-1:0] word_set;
    logic [WORD_BITS-1:0] word_clr;
    logic [CW-1:0]        alloc_unit;
    logic [CW-1:0]        cnt_dec;
    logic [CW-1:0]        cnt_inc;
    logic                 bit_used;
    logic                 slot;
    logic                 run_end;
    logic                 scan_emit;
    logic                 free_emit;
    logic                 err_emit;

    bra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (cur_reg),
        .wr_data (ram_wdata),
        .rd_en   (cmd.read),
        .rd_addr (cur_reg),
        .rd_data (ram_rdata)
    );

    // unit index to word and bit by reciprocal multiply plus one correction
    assign idx   = unum_reg - UNIT_W'(1);
    assign prod  = PW'(idx) * PW'(DIV_RECIP);
    assign qw    = DW'(q_reg) * DW'(WORD_BITS);
    assign r_raw = DW'(idx) - qw;
    assign r_fix = (r_raw >= DW'(WORD_BITS));
    assign r_fin = r_fix ? (r_raw - DW'(WORD_BITS)) : r_raw;
    assign q_fin = r_fix ? (q_reg + UNIT_W'(1)) : q_reg;

    // lowest clear bit of the current word
    always_comb
    begin
        fz_pos     = '0;
        have_clear = 1'b0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word_reg[i])
            begin
                fz_pos     = BW'(i);
                have_clear = 1'b1;
            end
        end
    end

    assign word_set   = word_reg | (WORD_BITS'(1) << fz_pos);
    assign word_clr   = word_reg & ~(WORD_BITS'(1) << bit_reg);
    assign alloc_unit = base_reg + CW'(fz_pos) + CW'(1);
    assign cnt_dec    = free_cnt_reg - CW'(1);
    assign cnt_inc    = free_cnt_reg + CW'(1);
    assign bit_used   = word_reg[bit_reg];
    assign slot       = !rsp_valid_reg || rsp_ready;
    assign run_end    = (rem_reg == COUNT_W'(1));
    assign scan_emit  = cmd.scan && have_clear && slot;
    assign free_emit  = cmd.free_op && slot;
    assign err_emit   = cmd.err && slot;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = word_reg;
        if (cmd.clear)
        begin
            ram_we    = 1'b1;
            ram_wdata = '0;
        end
        else if (cmd.scan)
        begin
            ram_we    = !have_clear || (scan_emit && run_end);
            ram_wdata = have_clear ? word_set : word_reg;
        end
        else if (free_emit)
        begin
            ram_we    = bit_used;
            ram_wdata = word_clr;
        end
    end

    always_comb
    begin
        func_next      = func_reg;
        unum_next      = unum_reg;
        rem_next       = rem_reg;
        cur_next       = cur_reg;
        base_next      = base_reg;
        hint_next      = hint_reg;
        hint_base_next = hint_base_reg;
        free_cnt_next  = free_cnt_reg;
        word_next      = word_reg;
        bit_next       = bit_reg;
        q_next         = q_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unit_next      = unit_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        free_left_next = free_left_reg;

        if (cmd.clear)
        begin
            cur_next = cur_reg + AW'(1);
        end

        if (cmd.accept)
        begin
            func_next = func;
            unum_next = unit_number;
            rem_next  = count;
            cur_next  = hint_reg;
            base_next = hint_base_reg;
        end

        if (cmd.div1)
        begin
            q_next = UNIT_W'(prod >> DIV_SHIFT);
        end

        if (cmd.div2)
        begin
            cur_next  = q_fin[AW-1:0];
            bit_next  = r_fin[BW-1:0];
            base_next = CW'(DW'(idx) - r_fin);
        end

        if (cmd.load)
        begin
            word_next = ram_rdata;
        end

        if (cmd.scan && !have_clear)
        begin
            cur_next  = cur_reg + AW'(1);
            base_next = base_reg + CW'(WORD_BITS);
        end

        if (scan_emit)
        begin
            word_next      = word_set;
            rem_next       = rem_reg - COUNT_W'(1);
            free_cnt_next  = cnt_dec;
            rsp_valid_next = 1'b1;
            unit_next      = alloc_unit[UNIT_W-1:0];
            status_next    = ST_ALLOC;
            last_next      = run_end;
            free_left_next = cnt_dec[UNIT_W-1:0];
            if (run_end)
            begin
                hint_next      = cur_reg;
                hint_base_next = base_reg;
            end
        end

        if (free_emit)
        begin
            rsp_valid_next = 1'b1;
            unit_next      = unum_reg;
            last_next      = 1'b1;
            if (bit_used)
            begin
                word_next      = word_clr;
                free_cnt_next  = cnt_inc;
                status_next    = ST_FREED;
                free_left_next = cnt_inc[UNIT_W-1:0];
                if (cur_reg < hint_reg)
                begin
                    hint_next      = cur_reg;
                    hint_base_next = base_reg;
                end
            end
            else
            begin
                status_next    = ST_BAD_FREE;
                free_left_next = free_cnt_reg[UNIT_W-1:0];
            end
        end

        if (err_emit)
        begin
            rsp_valid_next = 1'b1;
            last_next      = 1'b1;
            free_left_next = free_cnt_reg[UNIT_W-1:0];
            if (func_reg == FUNC_FREE)
            begin
                unit_next   = unum_reg;
                status_next = ST_BAD_FREE;
            end
            else
            begin
                unit_next   = '0;
                status_next = ST_REFUSED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            hint_reg      <= '0;
            hint_base_reg <= '0;
            free_cnt_reg  <= CW'(UNITS);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            hint_reg      <= hint_next;
            hint_base_reg <= hint_base_next;
            free_cnt_reg  <= free_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        unum_reg      <= unum_next;
        rem_reg       <= rem_next;
        base_reg      <= base_next;
        word_reg      <= word_next;
        bit_reg       <= bit_next;
        q_reg         <= q_next;
        unit_reg      <= unit_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
        free_left_reg <= free_left_next;
    end

    always_comb
    begin
        stat.clear_done = (cur_reg == AW'(MAP_WORDS - 1));
        stat.in_free    = (func == FUNC_FREE);
        stat.alloc_bad  = (count == '0) || (CW'(count) > free_cnt_reg)
                          || (count > COUNT_W'(MAX_RUN));
        stat.free_bad   = (unit_number == '0) || (CW'(unit_number) > CW'(UNITS));
        stat.op_free    = (func_reg == FUNC_FREE);
        stat.slot_free  = slot;
        stat.have_clear = have_clear;
        stat.run_end    = run_end;
    end

    assign rsp_valid = rsp_valid_reg;
    assign unit      = unit_reg;
    assign status    = status_reg;
    assign last      = last_reg;
    assign free_left = free_left_reg;

endmodule

// ===== hw/rtl/bitmap_run_allocator_core.sv =====
// top level of the bitmap run allocator: controller plus datapath
// depends on bra_pkg, bra_ctrl, bra_datapath
//
// channel  handshake              fields
// -------  ---------------------  -------------------------------------
// req      req_valid / req_ready  func, count, unit_number
// rsp      rsp_valid / rsp_ready  unit, status, last, free_left
//
// after reset the bitmap is zeroed, one word a cycle, ceil(UNITS/WORD_BITS)
// words (128 by default), with req_ready low
// free: accept, div1, div2, read, load, response; refused requests: accept,
// error response; allocate: read, load and scan of each bitmap word from the
// ram, from the lowest word that may hold a free unit, units granted in scan
// a stalled rsp port holds the search; one request is in work at a time
module bitmap_run_allocator_core
    import bra_pkg::*;
#(
    parameter int UNITS     = UNITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int MAX_RUN   = MAX_RUN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                func,
    input  logic [COUNT_W-1:0]  count,
    input  logic [UNIT_W-1:0]   unit_number,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [UNIT_W-1:0]   unit,
    output logic [STATUS_W-1:0] status,
    output logic                last,
    output logic [UNIT_W-1:0]   free_left
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    bra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .stat      (stat),
        .cmd       (cmd),
        .req_ready (req_ready)
    );

    bra_datapath #(
        .UNITS     (UNITS),
        .WORD_BITS (WORD_BITS),
        .MAX_RUN   (MAX_RUN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .func        (func),
        .count       (count),
        .unit_number (unit_number),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .unit        (unit),
        .status      (status),
        .last        (last),
        .free_left   (free_left)
    );

endmodule

// ===== hw/rtl/bra_checker.sv =====
// port-level checks for the bitmap run allocator, bound to the top level
// depends on bra_pkg and bitmap_run_allocator_core_macros.svh
`include "bitmap_run_allocator_core_macros.svh"

module bra_checker
    import bra_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [UNIT_W-1:0]   unit,
    input logic [STATUS_W-1:0] status,
    input logic                last,
    input logic [UNIT_W-1:0]   free_left
);

    `BRA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(unit) && $stable(status) && $stable(free_left),
        "response word changed while stalled")
    `BRA_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready,
        "request taken while previous one still in work")
    `BRA_ASSERT_IMPL(a_err_last, clk, rst_n,
        rsp_valid && (status == ST_REFUSED || status == ST_BAD_FREE), last,
        "error response not marked last")
    `BRA_ASSERT_IMPL(a_free_last, clk, rst_n, rsp_valid && status == ST_FREED, last,
        "free response not marked last")

endmodule

bind bitmap_run_allocator_core bra_checker u_chk (.*);
